### rtl/cla_pkg.sv
// shared types, constants and helpers for the chunked list appender
// depends on nothing; every rtl file uses it by scoped names
`timescale 1ns / 1ps

package cla_pkg;

   // sizing of the pool and the lists
   localparam int LAYERS      = 4;
   localparam int CHUNK_WORDS = 16;
   localparam int POOL_WORDS  = 2048;
   localparam int NUM_CHUNKS  = POOL_WORDS / CHUNK_WORDS;

   // fixed field widths of the streams
   localparam int LAYER_W = 2;
   localparam int WORD_W  = 64;
   localparam int ADDR_W  = 11;

   // derived state widths
   localparam int LAYER_IDX_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int CHUNK_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int NFC_W       = $clog2(NUM_CHUNKS + 1);
   localparam int SLOT_W      = $clog2(CHUNK_WORDS);

   // result queue
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   // packed stream widths
   localparam int REQ_USER_W = 1 + LAYER_W;
   localparam int RSP_BITS   = ADDR_W + WORD_W + ADDR_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   typedef enum logic [0:0] {
      CMD_APPEND = 1'b0,
      CMD_CLEAR  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_LINK  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [WORD_W-1:0]   data_word;
      logic [ADDR_W-1:0]   link_target;
      logic                starts_list;
      logic                last;
   } result_type;

   // how many results the core hands to the queue this cycle
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // first pool word of a chunk, low address bits only
   function automatic logic [ADDR_W-1:0] chunk_base(input logic [CHUNK_W-1:0] chunk);
      logic [31:0] full;
      full = 32'(chunk) * CHUNK_WORDS;
      return full[ADDR_W-1:0];
   endfunction

endpackage

### rtl/cla_core.sv
// per-layer list pointers, bump allocator and result generation
// depends on cla_pkg
`timescale 1ns / 1ps

module cla_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  cla_pkg::command_type           command,
   input  logic [cla_pkg::LAYER_W-1:0]    layer,
   input  logic [cla_pkg::WORD_W-1:0]     word,
   output cla_pkg::push_type              push,
   output cla_pkg::result_type            result0,
   output cla_pkg::result_type            result1
);

   logic                           open_ff  [cla_pkg::LAYERS];
   logic [cla_pkg::CHUNK_W-1:0]    chunk_ff [cla_pkg::LAYERS];
   logic [cla_pkg::SLOT_W-1:0]     slot_ff  [cla_pkg::LAYERS];
   logic [cla_pkg::NFC_W-1:0]      nfc_ff;

   logic                           open_in;
   logic [cla_pkg::CHUNK_W-1:0]    chunk_in;
   logic [cla_pkg::SLOT_W-1:0]     slot_in;
   logic [cla_pkg::NFC_W-1:0]      nfc_in;
   logic                           upd_layer;

   logic [cla_pkg::LAYER_IDX_W-1:0] idx;
   logic                            in_range;
   logic                            cur_open;
   logic [cla_pkg::CHUNK_W-1:0]     cur_chunk;
   logic [cla_pkg::SLOT_W-1:0]      cur_slot;
   logic [cla_pkg::CHUNK_W-1:0]     new_chunk;
   logic [cla_pkg::ADDR_W-1:0]      cur_base;
   logic [cla_pkg::ADDR_W-1:0]      new_base;
   logic                            need_chunk;
   logic                            pool_empty;
   logic                            adjacent;

   assign idx        = cla_pkg::LAYER_IDX_W'(layer);
   assign in_range   = int'(layer) < cla_pkg::LAYERS;
   assign cur_open   = open_ff[idx];
   assign cur_chunk  = chunk_ff[idx];
   assign cur_slot   = slot_ff[idx];
   assign new_chunk  = nfc_ff[cla_pkg::CHUNK_W-1:0];
   assign cur_base   = cla_pkg::chunk_base(cur_chunk);
   assign new_base   = cla_pkg::chunk_base(new_chunk);
   assign need_chunk = !cur_open || (32'(cur_slot) == cla_pkg::CHUNK_WORDS - 1);
   assign pool_empty = 32'(nfc_ff) >= cla_pkg::NUM_CHUNKS;
   assign adjacent   = nfc_ff == (cla_pkg::NFC_W'(cur_chunk) + 1'b1);

   always_comb begin
      push      = '{first: 1'b0, second: 1'b0};
      result0   = '0;
      result1   = '0;
      upd_layer = 1'b0;
      open_in   = cur_open;
      chunk_in  = cur_chunk;
      slot_in   = cur_slot;
      nfc_in    = nfc_ff;
      if (accept && command == cla_pkg::CMD_APPEND && in_range) begin
         push.first   = 1'b1;
         result0.last = 1'b1;
         if (need_chunk && pool_empty) begin
            result0.kind = cla_pkg::KIND_ERROR;
         end else if (!cur_open) begin
            // first word of the list opens a fresh chunk
            upd_layer           = 1'b1;
            nfc_in              = nfc_ff + 1'b1;
            open_in             = 1'b1;
            chunk_in            = new_chunk;
            slot_in             = cla_pkg::SLOT_W'(1);
            result0.kind        = cla_pkg::KIND_DATA;
            result0.address     = new_base;
            result0.data_word   = word;
            result0.starts_list = 1'b1;
         end else if (!need_chunk) begin
            upd_layer         = 1'b1;
            slot_in           = cur_slot + 1'b1;
            result0.kind      = cla_pkg::KIND_DATA;
            result0.address   = cur_base + cla_pkg::ADDR_W'(cur_slot);
            result0.data_word = word;
         end else if (adjacent) begin
            // contiguous chunk: the held-back slot just takes the word
            upd_layer         = 1'b1;
            nfc_in            = nfc_ff + 1'b1;
            chunk_in          = new_chunk;
            slot_in           = '0;
            result0.kind      = cla_pkg::KIND_DATA;
            result0.address   = cur_base + cla_pkg::ADDR_W'(cla_pkg::CHUNK_WORDS - 1);
            result0.data_word = word;
         end else begin
            // link in the held-back slot, then the word at the new chunk
            upd_layer           = 1'b1;
            nfc_in              = nfc_ff + 1'b1;
            chunk_in            = new_chunk;
            slot_in             = cla_pkg::SLOT_W'(1);
            push.second         = 1'b1;
            result0.kind        = cla_pkg::KIND_LINK;
            result0.address     = cur_base + cla_pkg::ADDR_W'(cla_pkg::CHUNK_WORDS - 1);
            result0.link_target = new_base;
            result0.last        = 1'b0;
            result1.kind        = cla_pkg::KIND_DATA;
            result1.address     = new_base;
            result1.data_word   = word;
            result1.last        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && command == cla_pkg::CMD_CLEAR)) begin
         for (int i = 0; i < cla_pkg::LAYERS; i++) begin
            open_ff[i]  <= 1'b0;
            chunk_ff[i] <= '0;
            slot_ff[i]  <= '0;
         end
         nfc_ff <= '0;
      end else if (upd_layer) begin
         open_ff[idx]  <= open_in;
         chunk_ff[idx] <= chunk_in;
         slot_ff[idx]  <= slot_in;
         nfc_ff        <= nfc_in;
      end
   end

endmodule

### rtl/cla_rspq.sv
// small result queue: takes up to two results a cycle, gives one
// depends on cla_pkg
`timescale 1ns / 1ps

module cla_rspq (
   input  logic                 clock,
   input  logic                 reset,
   input  cla_pkg::push_type    push,
   input  cla_pkg::result_type  din0,
   input  cla_pkg::result_type  din1,
   input  logic                 pop,
   output cla_pkg::result_type  head,
   output logic                 not_empty,
   output logic                 has_room
);

   cla_pkg::result_type             entry_ff [cla_pkg::RSPQ_DEPTH];
   logic [cla_pkg::RSPQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cla_pkg::RSPQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cla_pkg::RSPQ_CNT_W-1:0]  count_ff, count_in;
   logic [cla_pkg::RSPQ_PTR_W-1:0]  wr_ptr_next;
   logic [cla_pkg::RSPQ_CNT_W-1:0]  n_push;

   assign head        = entry_ff[rd_ptr_ff];
   assign not_empty   = count_ff != '0;
   // room for a two-result transaction regardless of the drain side
   assign has_room    = 32'(count_ff) <= cla_pkg::RSPQ_DEPTH - 2;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign n_push      = cla_pkg::RSPQ_CNT_W'(push.first) + cla_pkg::RSPQ_CNT_W'(push.second);
   assign wr_ptr_in   = wr_ptr_ff + cla_pkg::RSPQ_PTR_W'(n_push);
   assign rd_ptr_in   = rd_ptr_ff + cla_pkg::RSPQ_PTR_W'(pop);
   assign count_in    = count_ff + n_push - cla_pkg::RSPQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= din0;
      end
      if (push.second) begin
         entry_ff[wr_ptr_next] <= din1;
      end
   end

endmodule

### rtl/chunked_list_appender.sv
// each result is registered in the result queue before it shows on rsp_
// throughput: one request transaction per cycle while req_tready is high; rsp_ gives one
// result per cycle unless stalled, so a non-adjacent chunk crossing gives two results
// the four-entry result queue sets how far input runs ahead of a stalled output
// reset (synchronous, active high) closes every list, rewinds the allocator
// and empties the result queue; the block is ready in the next cycle
`timescale 1ns / 1ps

module chunked_list_appender (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cla_pkg::WORD_W-1:0]         req_tdata,   // [63:0] word
   input  logic [cla_pkg::REQ_USER_W-1:0]     req_tuser,   // [0] command, [2:1] layer
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cla_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [10:0] address,
                                                           // [74:11] data_word,
                                                           // [85:75] link_target,
                                                           // [86] starts_list, [87] zero
   output logic [cla_pkg::RSP_USER_W-1:0]     rsp_tuser,   // [1:0] kind
   output logic                               rsp_tlast    // last result of a transaction
);

   logic                 accept;
   cla_pkg::push_type    push;
   cla_pkg::result_type  result0;
   cla_pkg::result_type  result1;
   cla_pkg::result_type  head;
   logic                 has_room;

   // an incoming transaction is only taken when two queue entries are free
   assign req_tready = has_room;
   assign accept     = req_tvalid && req_tready;

   // pointer state and allocator; results are formed in the accept cycle
   cla_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .command (cla_pkg::command_type'(req_tuser[0])),
      .layer   (req_tuser[cla_pkg::LAYER_W:1]),
      .word    (req_tdata),
      .push    (push),
      .result0 (result0),
      .result1 (result1)
   );

   // registered results decouple the output handshake from the input
   cla_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din0      (result0),
      .din1      (result1),
      .pop       (rsp_tvalid && rsp_tready),
      .head      (head),
      .not_empty (rsp_tvalid),
      .has_room  (has_room)
   );

   // pack the head entry, address in the low bits
   assign rsp_tdata = cla_pkg::RSP_DATA_W'({head.starts_list, head.link_target,
                                            head.data_word, head.address});
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

### rtl/cla_checker.sv
// port-level checks for the chunked list appender, bound to the top level
// depends on cla_pkg and chunked_list_appender
`timescale 1ns / 1ps

module cla_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [cla_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic [cla_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               rsp_tlast
);

   // no result is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // kind is always one of the three defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == cla_pkg::KIND_DATA || rsp_tuser == cla_pkg::KIND_LINK
                      || rsp_tuser == cla_pkg::KIND_ERROR))
      else $error("undefined result kind");

   // an exhausted pool gives a single, all-zero closing result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == cla_pkg::KIND_ERROR) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("malformed error result");

   // a link is never last and is followed by the data word of the same transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser == cla_pkg::KIND_LINK) |->
         (!rsp_tlast ##1 (rsp_tvalid && rsp_tuser == cla_pkg::KIND_DATA && rsp_tlast)))
      else $error("link result not followed by its data word");

   // a waiting result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

endmodule

bind chunked_list_appender cla_checker u_cla_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
